// ===== sv/csdr_pkg.sv =====
package csdr_pkg;

	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_RESTART  = 2'd1;
	localparam logic [1:0] OP_ADVANCE  = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
	localparam logic [1:0] CFG_T_INCREMENT = 2'd1;
	localparam logic [1:0] CFG_MIN_DIST_SQ = 2'd2;

	localparam logic [16:0] T_ONE = 17'h10000;

	localparam int ACC_W = 40;

	typedef enum logic [1:0] {
		COEF_C,
		COEF_M0,
		COEF_P0
	} coef_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF,
		ST_SET,
		ST_MUL,
		ST_ADD,
		ST_SQ,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic      setup;
		logic      mul;
		logic      add;
		coef_sel_t sel;
	} lane_cmd_t;

endpackage

// ===== sv/closed_spline_distance_resampler_unit.sv =====
// channel | direction | handshake               | payload
// in      | to block  | in_valid / in_ready     | op, index, px, py, pz, slope_x/y/z
// out     | from block| out_valid / out_ready   | point_valid, x_out, y_out, z_out, segment, finished
// cfg     | to block  | cfg_valid / cfg_ready   | cfg_index, cfg_data
// One multiplier per axis lane runs the three Horner steps of an advance as multiply and
// round-add cycles, then the merge stage squares and compares. An advance after the walk
// ended goes straight to the compare state. Reset ends the walk, zeroes the threshold and
// sets point count 3 and t increment 66; the point stores hold garbage until loaded.
// A result waiting on out_ready holds the block in its compare state with in_ready low.
module closed_spline_distance_resampler_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [5:0]         index,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic signed [31:0] slope_x,
	input  logic signed [31:0] slope_y,
	input  logic signed [31:0] slope_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               point_valid,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic [5:0]         segment,
	output logic               finished,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [61:0]        cfg_data
);
	import csdr_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_nx;
	lane_cmd_t cmd;
	logic [1:0] rnd_q;

	logic [6:0]  point_count_q;
	logic [16:0] t_inc_q;
	logic [61:0] min_dist_q;

	logic [AW-1:0] seg_q, seg_eval_q;
	logic [16:0]   t_pos_q, t_eval_q;
	logic signed [31:0] ref_q [3];
	logic done_q, last_q, empty_q;

	logic out_valid_q, point_valid_q, finished_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic [5:0] segment_q;

	logic in_xfer, out_free, emit;
	logic [CW-1:0] cnt_c;
	logic [AW-1:0] seg_c, nxt_c, rd_a, rd_b, wr_addr;
	logic last_c, wr_en;
	logic [17:0] t_sum;
	logic [16:0] t_new;
	logic signed [31:0] p_a [3];
	logic signed [31:0] p_nx [3];
	logic signed [31:0] val [3];
	logic [63:0] wr_data [3];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (32'(point_count_q) < 3) begin
			cnt_c = CW'(3);
		end else if (32'(point_count_q) > MAX_POINTS) begin
			cnt_c = CW'(MAX_POINTS);
		end else begin
			cnt_c = CW'(point_count_q);
		end
		seg_c  = (32'(seg_q) >= 32'(cnt_c)) ? AW'(cnt_c - CW'(1)) : seg_q;
		last_c = (32'(seg_c) + 1) >= 32'(cnt_c);
		nxt_c  = last_c ? '0 : AW'(seg_c + AW'(1));
		t_sum  = 18'(t_pos_q) + 18'(t_inc_q);
		t_new  = (t_sum > 18'(T_ONE)) ? T_ONE : t_sum[16:0];
		rd_a   = (op == OP_RESTART) ? '0 : seg_c;
		rd_b   = nxt_c;
		wr_en  = in_xfer && (op == OP_LOAD) && (32'(index) < MAX_POINTS);
		wr_addr = AW'(index);
		wr_data[0] = {slope_x, px};
		wr_data[1] = {slope_y, py};
		wr_data[2] = {slope_z, pz};
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (op)
						OP_RESTART: state_nx = ST_REF;
						OP_ADVANCE: state_nx = done_q ? ST_CMP : ST_SET;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_REF:  state_nx = ST_IDLE;
			ST_SET:  state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_ADD;
			ST_ADD:  state_nx = (rnd_q == 2'd2) ? ST_SQ : ST_MUL;
			ST_SQ:   state_nx = ST_CMP;
			ST_CMP:  state_nx = out_free ? ST_IDLE : ST_CMP;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.setup = (state_q == ST_SET);
		cmd.mul   = (state_q == ST_MUL);
		cmd.add   = (state_q == ST_ADD);
		case (rnd_q)
			2'd0:    cmd.sel = COEF_C;
			2'd1:    cmd.sel = COEF_M0;
			default: cmd.sel = COEF_P0;
		endcase
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		csdr_lane #(.AW(AW)) u_lane (
			.clk       (clk),
			.wr_en     (wr_en),
			.wr_addr   (wr_addr),
			.wr_data   (wr_data[k]),
			.rd_addr_a (rd_a),
			.rd_addr_b (rd_b),
			.cmd       (cmd),
			.t         (t_eval_q),
			.p_a       (p_a[k]),
			.p_next    (p_nx[k]),
			.val       (val[k])
		);
	end

	csdr_merge u_merge (
		.clk         (clk),
		.sq_en       (state_q == ST_SQ),
		.p           (val),
		.ref_pt      (ref_q),
		.min_dist_sq (min_dist_q),
		.emit        (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rnd_q         <= '0;
			point_count_q <= 7'd3;
			t_inc_q       <= 17'd66;
			min_dist_q    <= '0;
			seg_q         <= '0;
			t_pos_q       <= '0;
			ref_q         <= '{default: '0};
			done_q        <= 1'b1;
			out_valid_q   <= 1'b0;
			empty_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_POINT_COUNT: point_count_q <= cfg_data[6:0];
					CFG_T_INCREMENT: t_inc_q       <= cfg_data[16:0];
					CFG_MIN_DIST_SQ: min_dist_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_SET) begin
				rnd_q <= '0;
			end else if (state_q == ST_ADD) begin
				rnd_q <= (rnd_q == 2'd2) ? 2'd0 : rnd_q + 2'd1;
			end
			if (in_xfer && (op == OP_RESTART)) begin
				seg_q   <= '0;
				t_pos_q <= '0;
				done_q  <= 1'b0;
			end
			if (in_xfer && (op == OP_ADVANCE)) begin
				empty_q <= done_q;
			end
			if (state_q == ST_REF) begin
				ref_q <= p_a;
			end
			if ((state_q == ST_CMP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ST_CMP) && out_free) begin
				if (!empty_q) begin
					if (t_eval_q == T_ONE) begin
						t_pos_q <= '0;
						if (last_q) begin
							done_q <= 1'b1;
							seg_q  <= '0;
							if (emit) begin
								ref_q <= val;
							end
						end else begin
							seg_q <= AW'(seg_eval_q + AW'(1));
							ref_q <= p_nx;
						end
					end else begin
						t_pos_q <= t_eval_q;
						if (emit) begin
							ref_q <= val;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (op == OP_ADVANCE)) begin
			t_eval_q   <= t_new;
			seg_eval_q <= done_q ? seg_q : seg_c;
			last_q     <= last_c;
		end
		if ((state_q == ST_CMP) && out_free) begin
			segment_q <= 6'(seg_eval_q);
			if (empty_q) begin
				point_valid_q <= 1'b0;
				x_q           <= '0;
				y_q           <= '0;
				z_q           <= '0;
				finished_q    <= 1'b1;
			end else begin
				point_valid_q <= emit;
				x_q           <= emit ? val[0] : '0;
				y_q           <= emit ? val[1] : '0;
				z_q           <= emit ? val[2] : '0;
				finished_q    <= (t_eval_q == T_ONE) && last_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign point_valid = point_valid_q;
	assign x_out       = x_q;
	assign y_out       = y_q;
	assign z_out       = z_q;
	assign segment     = segment_q;
	assign finished    = finished_q;

`ifndef ASSERT_OFF
	a_t_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		t_pos_q[16] == 1'b0) else $error("t position reached one");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q != 2'd3) else $error("Horner round out of range");
	a_sq_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> ($past(state_q) == ST_ADD && $past(rnd_q) == 2'd2))
		else $error("square stage entered early");
	a_zero_when_idle_pt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_valid) |-> (x_out == 0 && y_out == 0 && z_out == 0))
		else $error("coordinates nonzero without a point");
`endif

endmodule

// ===== sv/csdr_lane.sv =====
module csdr_lane #(
	parameter int AW = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [63:0]         wr_data,
	input  logic [AW-1:0]       rd_addr_a,
	input  logic [AW-1:0]       rd_addr_b,
	input  csdr_pkg::lane_cmd_t cmd,
	input  logic [16:0]         t,
	output logic signed [31:0]  p_a,
	output logic signed [31:0]  p_next,
	output logic signed [31:0]  val
);
	import csdr_pkg::*;

	logic [63:0] mem [2**AW];
	logic [63:0] rdata_a_q;
	logic [63:0] rdata_b_q;

	logic signed [ACC_W-1:0] p0, m0, p1, m1, c_new, d_new;
	logic signed [ACC_W-1:0] c_q, m0_q, p0_q, acc_q, coef;
	logic signed [31:0]      p1_q;
	logic signed [ACC_W+17:0] prod_q;
	logic signed [ACC_W+17:0] rnd;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_a_q <= mem[rd_addr_a];
		rdata_b_q <= mem[rd_addr_b];
	end

	always_comb begin
		p0 = ACC_W'(signed'(rdata_a_q[31:0]));
		m0 = ACC_W'(signed'(rdata_a_q[63:32]));
		p1 = ACC_W'(signed'(rdata_b_q[31:0]));
		m1 = ACC_W'(signed'(rdata_b_q[63:32]));
		c_new = 3 * (p1 - p0) - 2 * m0 - m1;
		d_new = 2 * (p0 - p1) + m0 + m1;
		case (cmd.sel)
			COEF_C:  coef = c_q;
			COEF_M0: coef = m0_q;
			COEF_P0: coef = p0_q;
			default: coef = '0;
		endcase
		rnd = (prod_q + (ACC_W+18)'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			c_q   <= c_new;
			m0_q  <= m0;
			p0_q  <= p0;
			p1_q  <= rdata_b_q[31:0];
			acc_q <= d_new;
		end else if (cmd.mul) begin
			prod_q <= acc_q * signed'({1'b0, t});
		end else if (cmd.add) begin
			acc_q <= ACC_W'(rnd) + coef;
		end
	end

	assign p_a    = rdata_a_q[31:0];
	assign p_next = p1_q;

	always_comb begin
		if (acc_q > ACC_W'(64'sh7FFFFFFF)) begin
			val = 32'sh7FFFFFFF;
		end else if (acc_q < -ACC_W'(64'sh80000000)) begin
			val = 32'sh80000000;
		end else begin
			val = acc_q[31:0];
		end
	end

endmodule

// ===== sv/csdr_merge.sv =====
module csdr_merge (
	input  logic               clk,
	input  logic               sq_en,
	input  logic signed [31:0] p [3],
	input  logic signed [31:0] ref_pt [3],
	input  logic [61:0]        min_dist_sq,
	output logic               emit
);
	import csdr_pkg::*;

	logic [63:0] sq_s1 [3];
	logic signed [32:0] diff [3];
	logic [31:0] mag [3];
	logic [65:0] sum;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = 33'(p[k]) - 33'(ref_pt[k]);
			mag[k]  = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (sq_en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= mag[k] * mag[k];
			end
		end
	end

	always_comb begin
		sum  = 66'(sq_s1[0]) + 66'(sq_s1[1]) + 66'(sq_s1[2]);
		emit = (sum[65:64] != 2'b00) || (sum[63:0] > 64'(min_dist_sq));
	end

endmodule

// ===== tb/sv/tb_closed_spline_distance_resampler_unit.sv =====
`timescale 1ns / 100ps

module tb_closed_spline_distance_resampler_unit;
	import csdr_pkg::*;

	typedef struct packed {
		logic        point_valid;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [5:0]  segment;
		logic        finished;
	} curve_point_t;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  index;
		logic [31:0] p [3];
		logic [31:0] m [3];
		bit          typed;
		curve_point_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [1:0] op;
	logic [5:0] index;
	logic signed [31:0] px, py, pz, slope_x, slope_y, slope_z;
	logic out_valid, out_ready;
	logic point_valid;
	logic signed [31:0] x_out, y_out, z_out;
	logic [5:0] segment;
	logic finished;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [61:0] cfg_data;

	closed_spline_distance_resampler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .index(index),
		.px(px), .py(py), .pz(pz), .slope_x(slope_x), .slope_y(slope_y), .slope_z(slope_z),
		.out_valid(out_valid), .out_ready(out_ready), .point_valid(point_valid),
		.x_out(x_out), .y_out(y_out), .z_out(z_out), .segment(segment), .finished(finished),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model state
	logic [31:0] pt_store [3][64];
	logic [31:0] sl_store [3][64];
	logic [5:0]  walk_seg;
	logic [16:0] walk_t;
	longint      ref_pt [3];
	bit          walk_over;
	logic [6:0]  cnt_reg;
	logic [16:0] step_reg;
	logic [61:0] thresh_reg;

	curve_point_t expected_points [$];
	int errors;
	int send_idle_pct, recv_idle_pct;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint round_half_up(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint hermite_axis(int ax, int s, int n, longint t);
		longint p0, m0, p1, m1, c, d, acc;
		p0 = sx32(pt_store[ax][s]);
		m0 = sx32(sl_store[ax][s]);
		p1 = sx32(pt_store[ax][n]);
		m1 = sx32(sl_store[ax][n]);
		c = 3 * (p1 - p0) - 2 * m0 - m1;
		d = 2 * (p0 - p1) + m0 + m1;
		acc = round_half_up(d * t) + c;
		acc = round_half_up(acc * t) + m0;
		acc = round_half_up(acc * t) + p0;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		return acc;
	endfunction

	function automatic void set_reference(int s);
		for (int a = 0; a < 3; a++) ref_pt[a] = sx32(pt_store[a][s]);
	endfunction

	function automatic void walk_step(stim_row_t r);
		curve_point_t res;
		int count, seg, nxt;
		bit last;
		logic [17:0] t;
		longint pv [3];
		logic [64:0] dsq;
		longint df;
		logic [63:0] sq;
		bit emit;
		case (r.op)
			OP_LOAD: begin
				for (int a = 0; a < 3; a++) begin
					pt_store[a][r.index] = r.p[a];
					sl_store[a][r.index] = r.m[a];
				end
			end
			OP_RESTART: begin
				walk_seg = 0;
				walk_t = 0;
				walk_over = 0;
				set_reference(0);
			end
			OP_ADVANCE: begin
				res = '{0, 0, 0, 0, walk_seg, 1};
				if (!walk_over) begin
					count = cnt_reg < 3 ? 3 : (cnt_reg > 64 ? 64 : int'(cnt_reg));
					seg = walk_seg >= count ? count - 1 : int'(walk_seg);
					last = seg + 1 >= count;
					nxt = last ? 0 : seg + 1;
					t = walk_t + step_reg;
					if (t > 18'h10000) t = 18'h10000;
					walk_t = t[16:0];
					dsq = 0;
					for (int a = 0; a < 3; a++) begin
						pv[a] = hermite_axis(a, seg, nxt, longint'(t));
						df = pv[a] - ref_pt[a];
						if (df < 0) df = -df;
						sq = df * df;
						dsq = dsq + sq;
						if (dsq[64]) dsq = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
					end
					emit = dsq[63:0] > {2'b00, thresh_reg};
					if (emit) for (int a = 0; a < 3; a++) ref_pt[a] = pv[a];
					res.point_valid = emit;
					if (emit) begin
						res.x = pv[0][31:0];
						res.y = pv[1][31:0];
						res.z = pv[2][31:0];
					end
					res.segment = seg[5:0];
					res.finished = 0;
					if (t >= 18'h10000) begin
						walk_t = 0;
						if (last) begin
							walk_over = 1;
							walk_seg = 0;
							res.finished = 1;
						end else begin
							walk_seg = 6'(seg + 1);
							set_reference(seg + 1);
						end
					end
				end
				if (r.typed && res !== r.want) begin
					$display("%0t directed row expected pv=%0b x=%h y=%h z=%h seg=%0d fin=%0b",
						$time, r.want.point_valid, r.want.x, r.want.y, r.want.z,
						r.want.segment, r.want.finished);
					$display("%0t directed row actual   pv=%0b x=%h y=%h z=%h seg=%0d fin=%0b",
						$time, res.point_valid, res.x, res.y, res.z, res.segment,
						res.finished);
					errors++;
				end
				expected_points = {expected_points, res};
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(stim_row_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		index <= r.index;
		px <= r.p[0]; py <= r.p[1]; pz <= r.p[2];
		slope_x <= r.m[0]; slope_y <= r.m[1]; slope_z <= r.m[2];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		walk_step(r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [61:0] val);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_POINT_COUNT: cnt_reg = val[6:0];
			CFG_T_INCREMENT: step_reg = val[16:0];
			CFG_MIN_DIST_SQ: thresh_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(bit wide);
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return wide ? $urandom() : 32'(signed'($urandom_range(400000)) - 200000);
		endcase
	endfunction

	function automatic stim_row_t mk_row(logic [1:0] o, logic [5:0] i, bit wide);
		stim_row_t r;
		r.op = o;
		r.index = i;
		for (int a = 0; a < 3; a++) begin
			r.p[a] = rand_coord(wide);
			r.m[a] = rand_coord(wide);
		end
		r.typed = 0;
		r.want = '{0, 0, 0, 0, 0, 0};
		return r;
	endfunction

	function automatic stim_row_t fixed_row(logic [1:0] o, logic [5:0] i, logic [31:0] v,
			logic [31:0] s);
		stim_row_t r;
		r = mk_row(o, i, 0);
		for (int a = 0; a < 3; a++) begin
			r.p[a] = v;
			r.m[a] = s;
		end
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [5:0] seg_v);
		stim_row_t r;
		r = mk_row(OP_ADVANCE, 0, 0);
		r.typed = 1;
		r.want = '{0, 0, 0, 0, seg_v, 1};
		return r;
	endfunction

	always @(posedge clk) begin
		curve_point_t got, w;
		if (arst_n && out_valid && out_ready) begin
			got = '{point_valid, x_out, y_out, z_out, segment, finished};
			if (expected_points.size() == 0) begin
				$display("%0t unexpected result pv=%0b x=%h y=%h z=%h seg=%0d fin=%0b", $time,
					got.point_valid, got.x, got.y, got.z, got.segment, got.finished);
				errors++;
			end else begin
				w = expected_points.pop_front();
				if (got !== w) begin
					$display("%0t expected pv=%0b x=%h y=%h z=%h seg=%0d fin=%0b", $time,
						w.point_valid, w.x, w.y, w.z, w.segment, w.finished);
					$display("%0t actual   pv=%0b x=%h y=%h z=%h seg=%0d fin=%0b", $time,
						got.point_valid, got.x, got.y, got.z, got.segment, got.finished);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic load_all(int n, bit wide);
		for (int i = 0; i < n; i++) send_item(mk_row(OP_LOAD, i[5:0], wide));
	endtask

	task automatic run_walk(int advances, bit noise);
		int o;
		send_item(mk_row(OP_RESTART, 0, 0));
		for (int k = 0; k < advances; k++) begin
			o = noise ? $urandom_range(19) : 0;
			if (o == 0) send_item(mk_row(OP_ADVANCE, 6'($urandom()), 0));
			else if (o == 1) send_item(mk_row(OP_RESERVED, 6'($urandom()), 1));
			else if (o == 2) send_item(mk_row(OP_RESTART, 6'($urandom()), 0));
			else if (o == 3) send_item(mk_row(OP_LOAD, 6'($urandom_range(2)), 0));
			else send_item(mk_row(OP_ADVANCE, 6'($urandom()), 0));
		end
	endtask

	initial begin
		stim_row_t table_rows [$];
		errors = 0;
		send_idle_pct = 28;
		recv_idle_pct = 51;
		arst_n = 1'b0;
		in_valid = 0; op = 0; index = 0;
		px = 0; py = 0; pz = 0; slope_x = 0; slope_y = 0; slope_z = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		walk_seg = 0; walk_t = 0; walk_over = 1;
		for (int a = 0; a < 3; a++) ref_pt[a] = 0;
		cnt_reg = 3; step_reg = 66; thresh_reg = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: advance before restart, extremes, unused op, restart and first advances
		table_rows = {table_rows, typed_row(0)};
		table_rows = {table_rows, fixed_row(OP_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
		table_rows = {table_rows, fixed_row(OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000)};
		table_rows = {table_rows, fixed_row(OP_LOAD, 2, 32'h0000_0000, 32'hFFFF_FFFF)};
		table_rows = {table_rows, fixed_row(OP_LOAD, 63, 32'hFFFF_FFFF, 32'h0001_0000)};
		table_rows = {table_rows, fixed_row(OP_RESERVED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
		table_rows = {table_rows, fixed_row(OP_RESTART, 0, 0, 0)};
		for (int k = 0; k < 4; k++) table_rows = {table_rows, mk_row(OP_ADVANCE, 0, 0)};
		foreach (table_rows[i]) send_item(table_rows[i]);
		wait_drained();

		write_reg(CFG_T_INCREMENT, 62'd65536);
		write_reg(CFG_MIN_DIST_SQ, 62'h3FFF_FFFF_FFFF_FFFF);
		write_reg(CFG_POINT_COUNT, 62'd64);
		load_all(64, 1);
		send_item(mk_row(OP_RESTART, 0, 0));
		for (int k = 0; k < 66; k++) send_item(mk_row(OP_ADVANCE, 0, 0));
		send_item(typed_row(0));
		wait_drained();

		write_reg(CFG_T_INCREMENT, 62'd40000);
		write_reg(CFG_MIN_DIST_SQ, 62'd0);
		write_reg(CFG_POINT_COUNT, 62'd0);
		run_walk(8, 0);
		wait_drained();
		write_reg(CFG_POINT_COUNT, 62'd127);
		wait_drained();
		run_walk(140, 1);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 28 : (phase == 1 ? 51 : 0);
			recv_idle_pct = phase == 0 ? 51 : (phase == 1 ? 28 : 0);
			write_reg(CFG_POINT_COUNT, 62'($urandom_range(3, 8)));
			write_reg(CFG_T_INCREMENT, 62'($urandom_range(1) ? $urandom_range(4000, 30000)
				: $urandom_range(1, 65536)));
			write_reg(CFG_MIN_DIST_SQ,
				62'({$urandom(), $urandom()} >> $urandom_range(2, 61)));
			load_all(8, phase == 2);
			run_walk(90, 1);
			wait_drained();
		end
		write_reg(CFG_T_INCREMENT, 62'd1);
		write_reg(CFG_POINT_COUNT, 62'd3);
		run_walk(30, 0);
		wait_drained();
		write_reg(CFG_T_INCREMENT, 62'd0);
		run_walk(20, 0);
		wait_drained();

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
